### rtl/core/stc_pkg.sv
`default_nettype none
package stc_pkg;
  localparam int FracBits = 8;
  localparam int StepIntervalMs = 2;
  localparam int PosBits = 20;
  localparam int ProdFrac = 16 + FracBits;
  localparam int PeriodBits = PosBits + 1 + ProdFrac;
  localparam int ProdBits = 56;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    KindTick = 2'd0,
    KindHome = 2'd1,
    KindInval = 2'd2,
    KindNone = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RegWidth = 2'd0,
    RegPitch = 2'd1,
    RegTimeout = 2'd2
  } reg_e;

  typedef struct packed {
    kind_e kind;
    logic signed [31:0] spool_rev;
    logic left_sw;
    logic right_sw;
    logic run_enabled;
    logic [31:0] now_ms;
    logic signed [21:0] homed_steps;
  } req_t;
endpackage
`default_nettype wire

### rtl/core/stc_front.sv
`default_nettype none
module stc_front (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic flush_i,
  input wire logic valid_i,
  output logic ready_o,
  input wire stc_pkg::req_t req_i,
  output logic q_valid_o,
  input wire logic q_ready_i,
  output stc_pkg::req_t q_req_o
);
  import stc_pkg::*;

  req_t mem_q [QueueDepth];
  logic wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop;

  assign ready_o = (cnt_q != 2'(QueueDepth));
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o = mem_q[rp_q];
  assign push = valid_i && ready_o;
  assign pop = q_valid_o && q_ready_i;

  always_comb begin
    wp_d = wp_q + 1'(push);
    rp_d = rp_q + 1'(pop);
    cnt_d = cnt_q + 2'(push) - 2'(pop);
    if (flush_i) begin
      wp_d = 1'b0;
      rp_d = 1'b0;
      cnt_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= req_i;
    end
  end
endmodule
`default_nettype wire

### rtl/core/stc_back.sv
`default_nettype none
module stc_back (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic clear_i,
  input wire logic [19:0] width_i,
  input wire logic [23:0] pitch_i,
  input wire logic [31:0] timeout_i,
  input wire logic q_valid_i,
  output logic q_ready_o,
  input wire stc_pkg::req_t q_req_i,
  output logic valid_o,
  input wire logic ready_i,
  output logic step_pulse_o,
  output logic move_right_o,
  output logic drive_enable_o,
  output logic [27:0] target_q8_o,
  output logic [19:0] position_steps_o,
  output logic miss_fault_o,
  output logic position_ok_o,
  output logic pitch_locked_o
);
  import stc_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StMul, StMod, StEval, StOut
  } state_e;

  localparam int WqBits = PosBits + FracBits + 1;
  // The product magnitude stays below 2^(ProdBits-1) and the period is at least
  // 2^(ProdFrac+1), so this many doublings of the period cover the product.
  localparam int ModSteps = ProdBits - 2 - ProdFrac;
  localparam int DivBits = PeriodBits + ModSteps;

  state_e state_q, state_d;
  req_t req_q;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [31:0] last_q, last_d, since_q, since_d;
  logic seen_q, seen_d, fault_q, fault_d, pv_q, pv_d;
  logic signed [ProdBits-1:0] prod_q, prod_d;
  logic [ProdBits-1:0] rem_q, rem_d;
  logic [DivBits-1:0] div_q, div_d;
  logic [5:0] cnt_q, cnt_d;
  logic step_q, step_d, dir_q, dir_d, act_q, act_d, ov_q, ov_d;
  logic [27:0] tgt_q, tgt_d;

  logic [PosBits-1:0] w;
  logic cfg_ok;
  logic [PeriodBits-1:0] period, wide, fold, ph;
  logic [WqBits-1:0] wq, pq, posq, tq;
  logic [WqBits:0] err;
  logic blocked, near_l, near_r, missing, stepping;
  logic [PosBits-1:0] npos;
  logic signed [22:0] hs;

  assign w = width_i;
  assign cfg_ok = (width_i != '0) && (pitch_i != '0) && (timeout_i != '0);
  assign period = {w, 1'b0, {ProdFrac{1'b0}}};
  assign wide = {1'b0, w, {ProdFrac{1'b0}}};
  assign wq = {1'b0, w, {FracBits{1'b0}}};
  assign pq = WqBits'(pitch_i);
  assign q_ready_o = (state_q == StIdle) && !ov_q;

  always_comb begin
    state_d = state_q;
    pos_d = pos_q; last_d = last_q; since_d = since_q;
    seen_d = seen_q; fault_d = fault_q; pv_d = pv_q;
    prod_d = prod_q; rem_d = rem_q; div_d = div_q; cnt_d = cnt_q;
    step_d = step_q; dir_d = dir_q; act_d = act_q; tgt_d = tgt_q; ov_d = ov_q;
    ph = '0; fold = '0; tq = '0; posq = '0; err = '0; blocked = 1'b0;
    near_l = 1'b0; near_r = 1'b0; missing = 1'b0; stepping = 1'b0; npos = pos_q;
    hs = '0;
    if (ov_q && ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (q_valid_i && !ov_q) begin
          step_d = 1'b0; dir_d = 1'b0; act_d = 1'b0; tgt_d = '0;
          state_d = StOut;
          case (q_req_i.kind)
            KindHome: begin
              if (cfg_ok) begin
                hs = 23'(q_req_i.homed_steps);
                if (hs < 0) begin
                  npos = '0;
                end else if (hs > $signed({3'b0, w})) begin
                  npos = w;
                end else begin
                  npos = hs[PosBits-1:0];
                end
                posq = {1'b0, npos, {FracBits{1'b0}}};
                pos_d = npos; since_d = '0; fault_d = 1'b0; pv_d = 1'b1;
                seen_d = (posq > pq) && ({1'b0, posq} < {1'b0, wq} - {1'b0, pq});
              end
            end
            KindInval: begin
              pv_d = 1'b0; since_d = '0; seen_d = 1'b0;
            end
            KindTick: begin
              if (cfg_ok && q_req_i.run_enabled && !fault_q && pv_q) begin
                state_d = StMul;
              end
            end
            default: ;
          endcase
        end
      end
      StMul: begin
        prod_d = ProdBits'(req_q.spool_rev) * $signed({1'b0, pitch_i});
        state_d = StMod;
        cnt_d = 6'(ModSteps + 1);
      end
      StMod: begin
        if (cnt_q == 6'(ModSteps + 1)) begin
          rem_d = prod_q[ProdBits-1] ? ProdBits'(-prod_q) : ProdBits'(prod_q);
          div_d = DivBits'(period) << ModSteps;
          cnt_d = cnt_q - 6'd1;
        end else begin
          if (DivBits'(rem_q) >= div_q) begin
            rem_d = rem_q - ProdBits'(div_q);
          end
          div_d = div_q >> 1;
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            state_d = StEval;
          end
        end
      end
      StEval: begin
        ph = PeriodBits'(rem_q);
        if (prod_q[ProdBits-1] && rem_q != '0) begin
          ph = period - PeriodBits'(rem_q);
        end
        fold = (ph <= wide) ? ph : period - ph;
        tq = WqBits'(fold >> 16);
        tgt_d = 28'(tq);
        act_d = 1'b1;
        posq = {1'b0, pos_q, {FracBits{1'b0}}};
        dir_d = tq >= posq;
        err = dir_d ? {1'b0, tq - posq} : {1'b0, posq - tq};
        blocked = (dir_d && req_q.right_sw) || (!dir_d && req_q.left_sw);
        stepping = (err >= (WqBits+1)'(1 << (FracBits - 1))) &&
          ((req_q.now_ms - last_q) >= 32'(StepIntervalMs)) && !blocked;
        step_d = stepping;
        npos = pos_q;
        if (stepping) begin
          last_d = req_q.now_ms;
          if (dir_d) begin
            if (pos_q < w) npos = pos_q + 1'b1;
          end else if (pos_q != '0) begin
            npos = pos_q - 1'b1;
          end
        end
        posq = {1'b0, npos, {FracBits{1'b0}}};
        near_l = tq <= pq;
        near_r = {1'b0, tq} >= {1'b0, wq} - {1'b0, pq};
        seen_d = seen_q || ((posq > pq) && ({1'b0, posq} < {1'b0, wq} - {1'b0, pq}));
        missing = seen_d &&
          ((near_l && !req_q.left_sw && posq <= WqBits'(1 << FracBits)) ||
           (near_r && !req_q.right_sw &&
            {1'b0, posq} >= {1'b0, wq} - (WqBits+1)'(1 << FracBits)));
        if (missing) begin
          since_d = (since_q != '0) ? since_q :
                    ((req_q.now_ms == '0) ? 32'd1 : req_q.now_ms);
          if ((req_q.now_ms - since_d) >= timeout_i) fault_d = 1'b1;
        end else begin
          since_d = '0;
        end
        if (req_q.left_sw) npos = '0;
        if (req_q.right_sw) npos = w;
        pos_d = npos;
        state_d = StOut;
      end
      StOut: begin
        ov_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (clear_i) begin
      pos_d = '0; last_d = '0; since_d = '0; seen_d = 1'b0; fault_d = 1'b0; pv_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ov_q <= 1'b0;
      pos_q <= '0; last_q <= '0; since_q <= '0;
      seen_q <= 1'b0; fault_q <= 1'b0; pv_q <= 1'b1;
    end else begin
      state_q <= state_d; ov_q <= ov_d;
      pos_q <= pos_d; last_q <= last_d; since_q <= since_d;
      seen_q <= seen_d; fault_q <= fault_d; pv_q <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i && !ov_q) req_q <= q_req_i;
    prod_q <= prod_d; rem_q <= rem_d; div_q <= div_d; cnt_q <= cnt_d;
    step_q <= step_d; dir_q <= dir_d; act_q <= act_d; tgt_q <= tgt_d;
  end

  assign valid_o = ov_q;
  assign step_pulse_o = step_q;
  assign move_right_o = dir_q;
  assign drive_enable_o = act_q && !fault_q;
  assign target_q8_o = tgt_q;
  assign position_steps_o = pos_q;
  assign miss_fault_o = fault_q;
  assign position_ok_o = pv_q;
  assign pitch_locked_o = act_q;
endmodule
`default_nettype wire

### rtl/core/spool_traverse_stepper_control.sv
`default_nettype none
// An enabled control tick goes from idle through multiply, the one-bit-per-cycle reduction of
// the winding product modulo twice the width (31 steps), evaluate and output; home, invalidate
// and unknown requests, and ticks that do not run, go from idle straight to output. A two-entry
// queue accepts further requests while one is processed, the result waits in an output register,
// and the next request starts in the cycle after that result is taken.
module spool_traverse_stepper_control (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [3:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input wire logic in_valid_i,
  output logic in_ready_o,
  input wire logic [1:0] kind_i,
  input wire logic signed [31:0] spool_rev_i,
  input wire logic left_sw_i,
  input wire logic right_sw_i,
  input wire logic run_enabled_i,
  input wire logic [31:0] now_ms_i,
  input wire logic signed [21:0] homed_steps_i,
  output logic out_valid_o,
  input wire logic out_ready_i,
  output logic step_pulse_o,
  output logic move_right_o,
  output logic drive_enable_o,
  output logic [27:0] target_q8_o,
  output logic [19:0] position_steps_o,
  output logic miss_fault_o,
  output logic position_ok_o,
  output logic pitch_locked_o
);
  import stc_pkg::*;

  logic [19:0] width_q;
  logic [23:0] pitch_q;
  logic [31:0] tmo_q;
  logic wr, clear;
  req_t req, qreq;
  logic qv, qr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign clear = wr && (paddr[3:2] != 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0; pitch_q <= '0; tmo_q <= '0;
    end else if (wr) begin
      case (reg_e'(paddr[3:2]))
        RegWidth: width_q <= pwdata[19:0];
        RegPitch: pitch_q <= pwdata[23:0];
        RegTimeout: tmo_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      RegWidth: prdata = {12'd0, width_q};
      RegPitch: prdata = {8'd0, pitch_q};
      RegTimeout: prdata = tmo_q;
      default: prdata = '0;
    endcase
  end

  assign req = '{kind: kind_e'(kind_i), spool_rev: spool_rev_i,
    left_sw: left_sw_i, right_sw: right_sw_i, run_enabled: run_enabled_i,
    now_ms: now_ms_i, homed_steps: homed_steps_i};

  stc_front u_front (.clk_i, .rst_ni, .flush_i(1'b0), .valid_i(in_valid_i),
    .ready_o(in_ready_o), .req_i(req), .q_valid_o(qv), .q_ready_i(qr), .q_req_o(qreq));

  stc_back u_back (.clk_i, .rst_ni, .clear_i(clear), .width_i(width_q), .pitch_i(pitch_q),
    .timeout_i(tmo_q), .q_valid_i(qv), .q_ready_o(qr), .q_req_i(qreq),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .step_pulse_o, .move_right_o,
    .drive_enable_o, .target_q8_o, .position_steps_o, .miss_fault_o, .position_ok_o,
    .pitch_locked_o);
endmodule
`default_nettype wire

### rtl/core/stc_checker.sv
`default_nettype none
module stc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic step_pulse_o,
  input wire logic drive_enable_o,
  input wire logic miss_fault_o,
  input wire logic pitch_locked_o,
  input wire logic [27:0] target_q8_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_q8_o)) else $error("hold");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_pulse_o |-> pitch_locked_o) else $error("step");
  a_drv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_enable_o |-> !miss_fault_o && pitch_locked_o) else $error("drv");
  a_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pitch_locked_o |-> target_q8_o == 28'd0) else $error("tgt");
endmodule

bind spool_traverse_stepper_control stc_checker u_chk (.clk_i, .rst_ni, .out_valid_o,
  .out_ready_i, .step_pulse_o, .drive_enable_o, .miss_fault_o, .pitch_locked_o,
  .target_q8_o);
`default_nettype wire
